[rtl/core/bresenham_line_generator_unit_defines.svh]
// Assertion macros shared by the checker of the line generator.
`ifndef BRESENHAM_LINE_GENERATOR_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_GENERATOR_UNIT_DEFINES_SVH

// Property checked at every rising clock edge outside of reset.
`define BLG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define BLG_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/blg_pkg.sv]
package blg_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAME_BITS = 13;
   localparam int COLOR_BITS = 32;
   localparam int ERR_BITS   = COORD_BITS + 2;
   // Width used to compare a non-negative coordinate against a frame size.
   localparam int CMP_BITS   = (COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS;

   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(640);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(480);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] span_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic        [FRAME_BITS-1:0] frame_size_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type    op;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      color_type color;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      inside_res;
      logic      last;
   } rsp_type;

   typedef struct packed {
      coord_type cur_x;
      coord_type cur_y;
      coord_type target_x;
      coord_type target_y;
      span_type  span_x;
      span_type  span_y;
      err_type   error_term;
      color_type line_color;
   } line_state_type;

   typedef struct packed {
      frame_size_type width;
      frame_size_type height;
   } frame_type;

endpackage

[rtl/core/blg_csr.sv]
module blg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  blg_pkg::csr_index_type csr_index,
   input  blg_pkg::frame_size_type csr_wdata,
   output blg_pkg::frame_type    frame
);
   import blg_pkg::*;

   frame_type frame_ff;
   frame_type frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_in.width  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_in.height = csr_wdata;
            default:          frame_in = frame_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff.width  <= FRAME_WIDTH_RESET;
         frame_ff.height <= FRAME_HEIGHT_RESET;
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign frame = frame_ff;

endmodule

[rtl/core/blg_step.sv]
module blg_step (
   input  blg_pkg::req_type        req,
   input  blg_pkg::line_state_type state,
   input  blg_pkg::frame_type      frame,
   output blg_pkg::line_state_type state_next,
   output blg_pkg::rsp_type        rsp,
   output logic                    emit
);
   import blg_pkg::*;

   localparam coord_type ONE       = COORD_BITS'(1);
   localparam coord_type MINUS_ONE = '1;

   // Endpoint deltas one bit wider so that the difference never wraps.
   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   span_type  start_span_x;
   span_type  start_span_y;
   err_type   start_err;

   logic      at_end;
   logic signed [ERR_BITS:0] e2;
   logic signed [ERR_BITS:0] sx_ext;
   logic signed [ERR_BITS:0] neg_sy;
   logic      move_x;
   logic      move_y;
   coord_type step_x;
   coord_type step_y;
   coord_type moved_x;
   coord_type moved_y;
   err_type   moved_err;
   logic      inside_x;
   logic      inside_y;

   assign dx = $signed({req.end_x[COORD_BITS-1], req.end_x})
             - $signed({req.start_x[COORD_BITS-1], req.start_x});
   assign dy = $signed({req.end_y[COORD_BITS-1], req.end_y})
             - $signed({req.start_y[COORD_BITS-1], req.start_y});
   assign start_span_x = dx[COORD_BITS] ? span_type'(-dx) : span_type'(dx);
   assign start_span_y = dy[COORD_BITS] ? span_type'(-dy) : span_type'(dy);
   assign start_err    = $signed(ERR_BITS'(start_span_x)) - $signed(ERR_BITS'(start_span_y));

   assign at_end = (state.cur_x == state.target_x) && (state.cur_y == state.target_y);
   assign emit   = (req.op == OP_STEP) && !at_end;

   // Doubled error compared against -span_y and span_x; x or y moves, never both.
   assign e2     = $signed({state.error_term, 1'b0});
   assign sx_ext = $signed((ERR_BITS+1)'(state.span_x));
   assign neg_sy = -$signed((ERR_BITS+1)'(state.span_y));
   assign move_x = e2 > neg_sy;
   assign move_y = !move_x && (e2 < sx_ext);

   assign step_x  = (state.cur_x < state.target_x) ? ONE : MINUS_ONE;
   assign step_y  = (state.cur_y < state.target_y) ? ONE : MINUS_ONE;
   assign moved_x = move_x ? state.cur_x + step_x : state.cur_x;
   assign moved_y = move_y ? state.cur_y + step_y : state.cur_y;

   always_comb begin
      moved_err = state.error_term;
      if (move_x) begin
         moved_err = state.error_term - $signed(ERR_BITS'(state.span_y));
      end else if (move_y) begin
         moved_err = state.error_term + $signed(ERR_BITS'(state.span_x));
      end
   end

   always_comb begin
      state_next = state;
      if (req.op == OP_START) begin
         state_next.cur_x      = req.start_x;
         state_next.cur_y      = req.start_y;
         state_next.target_x   = req.end_x;
         state_next.target_y   = req.end_y;
         state_next.span_x     = start_span_x;
         state_next.span_y     = start_span_y;
         state_next.error_term = start_err;
         state_next.line_color = req.color;
      end else if (!at_end) begin
         state_next.cur_x      = moved_x;
         state_next.cur_y      = moved_y;
         state_next.error_term = moved_err;
      end
   end

   assign inside_x = !state.cur_x[COORD_BITS-1]
                   && (CMP_BITS'(unsigned'(state.cur_x)) < CMP_BITS'(frame.width));
   assign inside_y = !state.cur_y[COORD_BITS-1]
                   && (CMP_BITS'(unsigned'(state.cur_y)) < CMP_BITS'(frame.height));

   assign rsp.pixel_x     = state.cur_x;
   assign rsp.pixel_y     = state.cur_y;
   assign rsp.pixel_color = state.line_color;
   assign rsp.inside_res  = inside_x && inside_y;
   assign rsp.last        = (moved_x == state.target_x) && (moved_y == state.target_y);

endmodule

[rtl/core/bresenham_line_generator_unit.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    blg_pkg::req_type (start or step)
// rsp       out        rsp_valid/rsp_ready    blg_pkg::rsp_type (one pixel)
// csr       in         csr_write_en           csr_index, csr_wdata (frame size)
//
// Throughput is one request per cycle while rsp is not stalled; an accepted request
// enters the input register, and the walker result for it then loads the pixel register.
// Reset sets the frame to 640 by 480 and clears the line state, so a step
// before any start produces nothing. No clearing pass is needed.
// A stalled pixel holds the walker stage; the input register still takes
// one more request, after which req_ready drops.
module bresenham_line_generator_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  blg_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output blg_pkg::rsp_type        rsp_data,
   input  logic                    csr_write_en,
   input  blg_pkg::csr_index_type  csr_index,
   input  blg_pkg::frame_size_type csr_wdata
);
   import blg_pkg::*;

   // Input register: holds one request until the walker stage can process it.
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_req_ff;

   // Walker state: current point, target, spans, error term and color.
   line_state_type state_ff;
   line_state_type state_in;

   // Pixel register toward the consumer.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   frame_type      frame;
   line_state_type step_state;
   rsp_type        step_rsp;
   logic           step_emit;
   logic           advance;
   logic           fire;

   blg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .frame        (frame)
   );

   blg_step u_step (
      .req        (in_req_ff),
      .state      (state_ff),
      .frame      (frame),
      .state_next (step_state),
      .rsp        (step_rsp),
      .emit       (step_emit)
   );

   // The walker stage moves whenever the pixel register is empty or is being
   // drained in this cycle, so a fresh pixel can replace the one leaving.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   assign state_in = fire ? step_state : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire && step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_data;
      end
      if (fire && step_emit) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/core/blg_checker.sv]
`include "bresenham_line_generator_unit_defines.svh"

module blg_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input blg_pkg::req_type        req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input blg_pkg::rsp_type        rsp_data,
   input logic                    csr_write_en,
   input blg_pkg::csr_index_type  csr_index,
   input blg_pkg::frame_size_type csr_wdata
);
   import blg_pkg::*;

   logic unused_inputs;
   assign unused_inputs = req_valid ^ (^req_data) ^ csr_write_en ^ csr_index ^ (^csr_wdata);

   // Reset empties the pixel register.
   `BLG_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "pixel valid after reset")

   // A stalled pixel stays offered.
   `BLG_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid, "pixel dropped while stalled")

   // With no pending pixel the walker can always take a request.
   `BLG_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "request stalled with empty output")

   // A pixel flagged inside the frame has non-negative coordinates.
   `BLG_ASSERT(a_inside_nonneg, rsp_valid && rsp_data.inside_res |-> !rsp_data.pixel_x[COORD_BITS-1] && !rsp_data.pixel_y[COORD_BITS-1], "inside pixel with negative coordinate")

endmodule

bind bresenham_line_generator_unit blg_checker u_blg_checker (.*);
